// ----- rtl/fhle_pkg.sv -----
// ----------------------------------------------------------------------------
// fhle_pkg: shared types, constants and functions of the flame heat LED effect
// Field widths, fixed-point constants, command and state types, palette math.
// ----------------------------------------------------------------------------
package fhle_pkg;

    localparam int KEY_W   = 7;
    localparam int ROW_W   = 3;
    localparam int RND_W   = 15;
    localparam int CFG_W   = 4;
    localparam int COLOR_W = 8;
    localparam int HEAT_W  = 16;
    localparam int ALPHA_W = 17;
    localparam int VOL_W   = 9;
    localparam int TGT_W   = 18;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAME_SPEED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_LVL  = 1'd1;

    localparam logic [CFG_W-1:0] SPEED_RESET  = 4'd5;
    localparam logic [CFG_W-1:0] SMOOTH_RESET = 4'd5;

    localparam logic [HEAT_W-1:0] HEAT_RESET = 16'h6400;  // 100.0 in Q8.8
    localparam logic [HEAT_W-1:0] HEAT_MAX   = 16'hFF00;  // 255.0 in Q8.8
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
    localparam logic [TGT_W-1:0]   TGT_BASE  = 18'd23040; // 90.0 in Q8.8

    localparam logic [CFG_W-1:0] SPEED_FAST  = 4'd10;
    localparam logic [CFG_W-1:0] INTERVAL_TOP = 4'd11;
    localparam logic [VOL_W-1:0] VOL_BASE    = 9'd40;
    localparam logic [VOL_W-1:0] VOL_STEP    = 9'd18;

    localparam logic [7:0] PAL_RED_END    = 8'd85;
    localparam logic [7:0] PAL_YELLOW_END = 8'd170;

    localparam int MOD_STEPS = RND_W;
    localparam logic [3:0] MOD_LAST = 4'(MOD_STEPS - 1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ROW_W-1:0] row;
        logic [RND_W-1:0] rnd;
        logic             in_range;
        logic             upd;
    } t_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_MOD,
        BK_TGT,
        BK_MUL,
        BK_SUM,
        BK_OUT
    } t_back_st;

    // alpha = 1/(1 + 0.6*level) in Q1.16, level saturates at ten
    function automatic logic [ALPHA_W-1:0] alpha_of(input logic [CFG_W-1:0] lvl);
        logic [ALPHA_W-1:0] a;
        case (lvl)
            4'd0:    a = 17'd65536;
            4'd1:    a = 17'd40960;
            4'd2:    a = 17'd29789;
            4'd3:    a = 17'd23406;
            4'd4:    a = 17'd19275;
            4'd5:    a = 17'd16384;
            4'd6:    a = 17'd14247;
            4'd7:    a = 17'd12603;
            4'd8:    a = 17'd11299;
            4'd9:    a = 17'd10240;
            default: a = 17'd9362;
        endcase
        return a;
    endfunction

    // 40*row/6 in Q8.8, rounded to nearest
    function automatic logic [13:0] row_bias(input logic [ROW_W-1:0] row);
        logic [13:0] b;
        case (row)
            3'd0:    b = 14'd0;
            3'd1:    b = 14'd1707;
            3'd2:    b = 14'd3413;
            3'd3:    b = 14'd5120;
            3'd4:    b = 14'd6827;
            3'd5:    b = 14'd8533;
            3'd6:    b = 14'd10240;
            default: b = 14'd11947;
        endcase
        return b;
    endfunction

    // black -> red -> yellow -> white
    function automatic t_rgb palette(input logic [7:0] h);
        t_rgb c;
        logic [9:0] x;
        c = '0;
        x = '0;
        if (h < PAL_RED_END) begin
            x = 10'(h) * 10'd3;
            c.red = x[7:0];
        end else if (h < PAL_YELLOW_END) begin
            x = 10'(h - PAL_RED_END) * 10'd3;
            c.red = 8'hFF;
            c.green = x[7:0];
        end else begin
            x = 10'(h - PAL_YELLOW_END) * 10'd3;
            c.red = 8'hFF;
            c.green = 8'hFF;
            c.blue = x[7:0];
        end
        return c;
    endfunction

endpackage

// ----- rtl/fhle_in_if.sv -----
// ----------------------------------------------------------------------------
// fhle_in_if: key item channel
// Valid/ready channel carrying one key of one frame.
// ----------------------------------------------------------------------------
interface fhle_in_if import fhle_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic [ROW_W-1:0] key_row;
    logic [RND_W-1:0] random_word;
    logic             frame_start;

    modport source (output valid, key_index, key_row, random_word, frame_start,
                    input ready);
    modport sink   (input valid, key_index, key_row, random_word, frame_start,
                    output ready);
endinterface

// ----- rtl/fhle_out_if.sv -----
// ----------------------------------------------------------------------------
// fhle_out_if: key color channel
// Valid/ready channel carrying one key's RGB color.
// ----------------------------------------------------------------------------
interface fhle_out_if import fhle_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   out_key;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, out_key, red, green, blue, input ready);
    modport sink   (input valid, out_key, red, green, blue, output ready);
endinterface

// ----- rtl/fhle_front.sv -----
// ----------------------------------------------------------------------------
// fhle_front: item intake and frame classification
// Tracks the frame phase and tags each key item with update and range flags.
// ----------------------------------------------------------------------------
module fhle_front import fhle_pkg::*; #(
    parameter int NUM_KEYS = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fhle_in_if.sink          i_in,
    input  logic [CFG_W-1:0] i_speed,
    input  logic             i_q_ready,
    output logic             o_q_valid,
    output t_cmd             o_cmd
);

    logic [3:0] r_phase, n_phase;
    logic       r_upd, n_upd;
    logic [3:0] w_interval;
    logic [3:0] w_inc;
    logic       w_accept;

    assign i_in.ready = i_q_ready;
    assign w_accept   = i_in.valid && i_q_ready;
    assign o_q_valid  = i_in.valid;

    assign w_interval = (i_speed >= SPEED_FAST) ? 4'd1 : (INTERVAL_TOP - i_speed);
    assign w_inc      = r_phase + 4'd1;

    always_comb begin
        n_phase = r_phase;
        n_upd   = r_upd;
        if (i_in.frame_start) begin
            n_phase = (w_inc >= w_interval) ? 4'd0 : w_inc;
            n_upd   = (n_phase == 4'd0);
        end
    end

    always_comb begin
        o_cmd.key      = i_in.key_index;
        o_cmd.row      = i_in.key_row;
        o_cmd.rnd      = i_in.random_word;
        o_cmd.in_range = ({2'b00, i_in.key_index} < 9'(NUM_KEYS));
        o_cmd.upd      = n_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_upd   <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_upd   <= n_upd;
        end
    end

endmodule

// ----- rtl/fhle_queue.sv -----
// ----------------------------------------------------------------------------
// fhle_queue: two-entry command queue
// Decouples the intake from the heat update engine.
// ----------------------------------------------------------------------------
module fhle_queue import fhle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/fhle_back.sv -----
// ----------------------------------------------------------------------------
// fhle_back: heat update engine
// Reads the key's heat, on update items reduces the random word bit-serially,
// mixes toward the target and writes back, and drives the color output register.
// ----------------------------------------------------------------------------
module fhle_back import fhle_pkg::*; #(
    parameter int NUM_KEYS = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    input  logic [CFG_W-1:0] i_speed,
    input  logic [CFG_W-1:0] i_smooth,
    fhle_out_if.source       o_out
);

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [HEAT_W-1:0]   r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_vld;

    t_back_st r_st, n_st;
    t_cmd     r_cmd;

    logic [HEAT_W-1:0]  r_rdata;
    logic               r_rvld;
    logic [HEAT_W-1:0]  r_heat;
    logic [RND_W-1:0]   r_shift;
    logic [VOL_W-1:0]   r_rem;
    logic [3:0]         r_cnt;
    logic signed [TGT_W-1:0] r_target;
    logic [32:0]        r_p0;
    logic signed [35:0] r_p1;

    logic               r_out_valid;
    logic [KEY_W-1:0]   r_out_key;
    t_rgb               r_out_rgb;

    logic [8:0]         w_key_ext;
    logic [AW-1:0]      w_idx;
    logic [VOL_W-1:0]   w_vol;
    logic [VOL_W:0]     w_trial;
    logic               w_ge;
    logic [VOL_W-1:0]   w_rem_next;
    logic signed [18:0] w_tgt;
    logic [ALPHA_W-1:0] w_alpha;
    logic [ALPHA_W-1:0] w_keep;
    logic signed [36:0] w_sum;
    logic [35:0]        w_rnd;
    logic [19:0]        w_q;
    logic [HEAT_W-1:0]  w_new_heat;
    logic               w_out_free;
    t_rgb               w_rgb;

    assign w_key_ext = {2'b00, r_cmd.key};
    assign w_idx     = w_key_ext[AW-1:0];
    assign w_vol     = VOL_BASE + VOL_STEP * 9'(i_speed);

    // one restoring step of random_word mod volatility
    assign w_trial    = {r_rem, r_shift[RND_W-1]};
    assign w_ge       = (w_trial >= {1'b0, w_vol});
    assign w_rem_next = w_ge ? VOL_W'(w_trial - {1'b0, w_vol}) : w_trial[VOL_W-1:0];

    assign w_tgt = 19'(TGT_BASE) + 19'(row_bias(r_cmd.row)) + 19'({r_rem, 8'd0})
                 - 19'({w_vol, 7'd0});

    assign w_alpha = alpha_of((i_smooth > SPEED_FAST) ? SPEED_FAST : i_smooth);
    assign w_keep  = ALPHA_ONE - w_alpha;

    assign w_sum = $signed({4'd0, r_p0}) + 37'(r_p1);
    assign w_rnd = w_sum[35:0] + 36'd32768;
    assign w_q   = w_rnd[35:16];
    always_comb begin
        if (w_sum[36]) begin
            w_new_heat = '0;
        end else if (w_q > 20'(HEAT_MAX)) begin
            w_new_heat = HEAT_MAX;
        end else begin
            w_new_heat = w_q[HEAT_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_rgb      = r_cmd.in_range ? palette(r_heat[HEAT_W-1:8]) : t_rgb'('0);

    assign o_out.valid   = r_out_valid;
    assign o_out.out_key = r_out_key;
    assign o_out.red     = r_out_rgb.red;
    assign o_out.green   = r_out_rgb.green;
    assign o_out.blue    = r_out_rgb.blue;

    always_comb begin
        n_st        = r_st;
        o_cmd_ready = 1'b0;
        case (r_st)
            BK_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_st = BK_READ;
                end
            end
            BK_READ: n_st = BK_LOAD;
            BK_LOAD: n_st = (r_cmd.upd && r_cmd.in_range) ? BK_MOD : BK_OUT;
            BK_MOD: begin
                if (r_cnt == MOD_LAST) begin
                    n_st = BK_TGT;
                end
            end
            BK_TGT:  n_st = BK_MUL;
            BK_MUL:  n_st = BK_SUM;
            BK_SUM:  n_st = BK_OUT;
            BK_OUT: begin
                if (w_out_free) begin
                    n_st = BK_IDLE;
                end
            end
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // heat memory: registered read, single write port
    always_ff @(posedge i_clk) begin
        if (r_st == BK_READ && r_cmd.in_range) begin
            r_rdata <= r_mem[w_idx];
        end
        if (r_st == BK_SUM) begin
            r_mem[w_idx] <= w_new_heat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (r_st == BK_READ && r_cmd.in_range) begin
                r_rvld <= r_vld[w_idx];
            end
            if (r_st == BK_SUM) begin
                r_vld[w_idx] <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                end
            end
            BK_LOAD: begin
                r_heat  <= r_rvld ? r_rdata : HEAT_RESET;
                r_shift <= r_cmd.rnd;
                r_rem   <= '0;
                r_cnt   <= '0;
            end
            BK_MOD: begin
                r_rem   <= w_rem_next;
                r_shift <= {r_shift[RND_W-2:0], 1'b0};
                r_cnt   <= r_cnt + 4'd1;
            end
            BK_TGT:  r_target <= w_tgt[TGT_W-1:0];
            BK_MUL: begin
                r_p0 <= 33'(r_heat) * 33'(w_keep);
                r_p1 <= 36'(r_target) * 36'($signed({1'b0, w_alpha}));
            end
            BK_SUM:  r_heat <= w_new_heat;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_st == BK_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == BK_OUT && w_out_free) begin
            r_out_key <= r_cmd.key;
            r_out_rgb <= w_rgb;
        end
    end

endmodule

// ----- rtl/flame_heat_led_effect.sv -----
// ----------------------------------------------------------------------------
// flame_heat_led_effect: per-key flame lighting
// Keeps one Q8.8 heat value per key and turns it into an RGB palette color.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per key per frame: key index, keyboard row, a random
//   word and a frame-start mark on the first key of each frame. o_out returns
//   exactly one color item per input item, in order, with the key echoed.
//   Both channels use valid/ready; an item moves when both are high.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes flame_speed
//   (index 0) and smoothing_level (index 1); write only while the block is idle.
// Sequencing:
//   An item on an update frame passes the heat engine's read, load, bit-serial
//   modulo, target, multiply, sum and output states; any other item passes read,
//   load and output only, and the queue registers each item on its way. One item
//   is in the engine at a time, so that sequencer sets the rate; a two-entry queue
//   lets intake run ahead of it.
// Reset:
//   Synchronous, active low. Heat entries read as 100.0 until first written
//   (valid bit per key), frame phase and update flag clear, both config
//   registers return to 5. No clearing pass is needed.
// Stall:
//   A result waits in the output register while o_out.ready is low; the engine
//   holds, the queue fills, then i_in.ready drops.
// ----------------------------------------------------------------------------
module flame_heat_led_effect import fhle_pkg::*; #(
    parameter int NUM_KEYS = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fhle_in_if.sink              i_in,
    fhle_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // config registers
    logic [CFG_W-1:0] r_flame_speed;
    logic [CFG_W-1:0] r_smooth_lvl;

    // front -> queue -> back
    logic q_in_valid;
    logic q_in_ready;
    t_cmd q_in_cmd;
    logic q_out_valid;
    logic q_out_ready;
    t_cmd q_out_cmd;

    // write config; values are masked to the register width by the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flame_speed <= SPEED_RESET;
            r_smooth_lvl  <= SMOOTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLAME_SPEED: r_flame_speed <= i_cfg_data;
                CFG_SMOOTH_LVL:  r_smooth_lvl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify items: frame phase, update flag, key range
    fhle_front #(
        .NUM_KEYS(NUM_KEYS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_speed   (r_flame_speed),
        .i_q_ready (q_in_ready),
        .o_q_valid (q_in_valid),
        .o_cmd     (q_in_cmd)
    );

    // hold classified items until the engine is free
    fhle_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_in_valid),
        .o_push_ready (q_in_ready),
        .i_push_cmd   (q_in_cmd),
        .o_pop_valid  (q_out_valid),
        .i_pop_ready  (q_out_ready),
        .o_pop_cmd    (q_out_cmd)
    );

    // update heat and produce the color
    fhle_back #(
        .NUM_KEYS(NUM_KEYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_out_valid),
        .o_cmd_ready (q_out_ready),
        .i_cmd       (q_out_cmd),
        .i_speed     (r_flame_speed),
        .i_smooth    (r_smooth_lvl),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/fhle_chk.sv -----
// ----------------------------------------------------------------------------
// fhle_chk: port-level checks of the flame heat LED effect
// Output channel behavior, palette and key range consistency, bound to the top level.
// ----------------------------------------------------------------------------
module fhle_chk import fhle_pkg::*; #(
    parameter int NUM_KEYS = 128
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [KEY_W-1:0]   i_out_key,
    input logic [COLOR_W-1:0] i_red,
    input logic [COLOR_W-1:0] i_green,
    input logic [COLOR_W-1:0] i_blue
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("color item dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_key) && $stable(i_red) && $stable(i_green) && $stable(i_blue))
        else $error("color item changed while stalled");

    a_palette_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_green != 8'd0 || i_blue != 8'd0) |->
            i_red == 8'hFF && (i_blue == 8'd0 || i_green == 8'hFF))
        else $error("color outside the flame palette");

    a_dark_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ({2'b00, i_out_key} >= 9'(NUM_KEYS)) |->
            i_red == 8'd0 && i_green == 8'd0 && i_blue == 8'd0)
        else $error("key beyond the heat store is lit");

endmodule

bind flame_heat_led_effect fhle_chk #(
    .NUM_KEYS(NUM_KEYS)
) u_fhle_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_key   (o_out.out_key),
    .i_red       (o_out.red),
    .i_green     (o_out.green),
    .i_blue      (o_out.blue)
);

// ----- sim/flame_heat_led_effect_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flame_heat_led_effect_tb: self-checking bench for the flame heat LED effect
// Sends key items in bursts while the color side stalls on its own pattern.
// Each key color is predicted from a local heat model and checked in order.
// ----------------------------------------------------------------------------
module flame_heat_led_effect_tb;
    import fhle_pkg::*;

    localparam int NUM_KEYS     = 128;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;   // long hold-off of the color side
    localparam int SETTLE_CYCLES = 30;   // idle wait after a drain, longer than any one engine item
    localparam int MAX_PRINTED  = 40;

    // expected color of one key, one entry per accepted key item
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } key_color_t;

    // behavior of the color side between long holds
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    fhle_in_if  key_if ();
    fhle_out_if color_if ();

    flame_heat_led_effect #(
        .NUM_KEYS (NUM_KEYS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (key_if),
        .o_out      (color_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Local heat model: one Q8.8 heat per key, frame phase, update flag
    // and the two settings as the block should hold them.
    // ------------------------------------------------------------------
    logic [HEAT_W-1:0] key_heat [NUM_KEYS];
    logic [3:0]        phase_count;
    logic              update_active;
    logic [CFG_W-1:0]  speed_setting;
    logic [CFG_W-1:0]  smooth_setting;

    key_color_t color_queue [$];

    int  error_count;
    int  keys_sent;
    int  colors_checked;
    int  configs_applied;
    int  cycle_count;
    int  input_stall_cycles;
    int  hold_count;
    int  burst_left;
    int  gap_max;
    bit  valid_high;
    bit  hold_request;

    // Advance the frame state for one key item, update its heat on an update
    // frame and return the palette color of the integer heat.
    function automatic key_color_t predict_color(input logic [KEY_W-1:0] key,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [RND_W-1:0] rnd,
                                                 input logic start);
        key_color_t c;
        longint     vol;
        longint     alpha;
        longint     target;
        longint     mix;
        longint     q;
        int         interval;
        int         lvl;
        int         h;
        c = '0;
        c.key = key;
        if (start) begin
            // interval saturates at one for speeds of ten and up
            interval = (speed_setting >= 4'd10) ? 1 : 11 - int'(speed_setting);
            phase_count = phase_count + 4'd1;
            // a shrunken interval wraps the phase at once
            if (int'(phase_count) >= interval)
                phase_count = '0;
            update_active = (phase_count == 4'd0);
        end
        if (update_active) begin
            vol = 40 + 18 * longint'(speed_setting);
            lvl = (smooth_setting > 4'd10) ? 10 : int'(smooth_setting);
            alpha = longint'($rtoi(65536.0 / (1.0 + 0.6 * lvl) + 0.5));
            target = 90 * 256 + (5120 * longint'(row) + 1) / 3
                   + (longint'(rnd) % vol) * 256 - vol * 128;
            mix = longint'(key_heat[key]) * (65536 - alpha) + target * alpha;
            if (mix < 0) begin
                q = 0;
            end else begin
                q = (mix + 32768) >>> 16;
                if (q > longint'(HEAT_MAX))
                    q = longint'(HEAT_MAX);
            end
            key_heat[key] = HEAT_W'(q);
        end
        h = int'(key_heat[key][15:8]);
        if (h < int'(PAL_RED_END)) begin
            c.red = COLOR_W'(3 * h);
        end else if (h < int'(PAL_YELLOW_END)) begin
            c.red   = 8'hFF;
            c.green = COLOR_W'(3 * (h - int'(PAL_RED_END)));
        end else begin
            c.red   = 8'hFF;
            c.green = 8'hFF;
            c.blue  = COLOR_W'(3 * (h - int'(PAL_YELLOW_END)));
        end
        return c;
    endfunction

    task automatic note_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Offer one key item and hold it until the block takes it. Valid stays
    // high afterwards; a gap or a drain lowers it.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic [ROW_W-1:0] row,
                            input logic [RND_W-1:0] rnd, input logic start);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0)
                gap = $urandom_range(0, gap_max);
        end
        if (gap > 0) begin
            if (valid_high) begin
                key_if.valid <= 1'b0;
                valid_high = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        key_if.valid       <= 1'b1;
        key_if.key_index   <= key;
        key_if.key_row     <= row;
        key_if.random_word <= rnd;
        key_if.frame_start <= start;
        valid_high = 1'b1;
        do @(posedge i_clk); while (!key_if.ready);
        color_queue.push_back(predict_color(key, row, rnd, start));
        keys_sent++;
    endtask

    // Drop valid and wait for every expected color to come back.
    task automatic wait_drain();
        if (valid_high) begin
            key_if.valid <= 1'b0;
            valid_high = 1'b0;
        end
        do @(posedge i_clk); while (color_queue.size() != 0);
    endtask

    // Write both registers while the block is idle.
    task automatic set_config(input logic [CFG_W-1:0] speed,
                              input logic [CFG_W-1:0] smooth);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FLAME_SPEED;
        i_cfg_data <= speed;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SMOOTH_LVL;
        i_cfg_data <= smooth;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        speed_setting  = speed;
        smooth_setting = smooth;
        configs_applied++;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Keys before any frame start never update: heat stays at its reset.
    task automatic test_before_first_frame();
        send_key(KEY_W'(0), ROW_W'(7), RND_W'(15'h7FFF), 1'b0);
        send_key(KEY_W'(NUM_KEYS - 1), ROW_W'(0), RND_W'(0), 1'b0);
        wait_drain();
    endtask

    // Top speed with no smoothing drives heat to both clamps; then saturate
    // the smoothing level above ten.
    task automatic test_config_extremes();
        set_config(4'd15, 4'd0);
        send_key(KEY_W'(5), ROW_W'(0), RND_W'(0), 1'b1);              // clamp at zero
        send_key(KEY_W'(6), ROW_W'(7), RND_W'(309), 1'b1);            // clamp at 255.0
        send_key(KEY_W'(NUM_KEYS - 1), ROW_W'(7), RND_W'(15'h7FFF), 1'b1);
        send_key(KEY_W'(0), ROW_W'(3), RND_W'(15'h5555), 1'b0);
        set_config(SPEED_FAST, 4'd15);
        send_key(KEY_W'(5), ROW_W'(5), RND_W'(15'h2AAA), 1'b1);
        send_key(KEY_W'(6), ROW_W'(6), RND_W'(15'h7FFF), 1'b0);
        send_key(KEY_W'(NUM_KEYS - 1), ROW_W'(1), RND_W'(0), 1'b1);
        wait_drain();
    endtask

    // Count the phase up on a long interval, then shrink the interval below
    // the phase so the next frame start wraps it.
    task automatic test_interval_shrink();
        int k;
        set_config(4'd0, SMOOTH_RESET);
        for (k = 0; k < 9; k++)
            send_key(KEY_W'(k), ROW_W'(k), RND_W'($urandom), 1'b1);
        set_config(4'd8, SMOOTH_RESET);
        send_key(KEY_W'(2), ROW_W'(7), RND_W'($urandom), 1'b1);
        send_key(KEY_W'(3), ROW_W'(2), RND_W'($urandom), 1'b0);
        wait_drain();
    endtask

    // Hold the color side off for a long stretch while keys keep coming, so
    // the block's queue fills and it stops taking items.
    task automatic test_backpressure();
        int k;
        set_config(4'd2, 4'd3);
        gap_max = 0;
        hold_request = 1'b1;
        for (k = 0; k < 24; k++)
            send_key(KEY_W'($urandom_range(0, 15)), ROW_W'($urandom_range(0, 7)),
                     RND_W'($urandom), k % 8 == 0);
        wait_drain();
    endtask

    // Mostly well-formed frames (start mark on the first key only) with random
    // content; about one frame in ten carries random start marks.
    task automatic test_random_frames(input int n_items, input logic [CFG_W-1:0] speed,
                                      input logic [CFG_W-1:0] smooth, input int gaps);
        int sent;
        int frame_len;
        int key_span;
        int k;
        bit noisy;
        set_config(speed, smooth);
        gap_max = gaps;
        sent = 0;
        while (sent < n_items) begin
            frame_len = $urandom_range(1, 12);
            noisy = ($urandom_range(0, 9) == 0);
            // a small key pool revisits the same heat entries often
            key_span = ($urandom_range(0, 1) == 0) ? 7 : NUM_KEYS - 1;
            for (k = 0; k < frame_len; k++) begin
                send_key(KEY_W'($urandom_range(0, key_span)), ROW_W'($urandom_range(0, 7)),
                         RND_W'($urandom),
                         noisy ? 1'($urandom_range(0, 1)) : 1'(k == 0));
                sent++;
            end
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Color side: ready follows a mode picked at random for a random stretch;
    // on request, hold ready low for a long counted stretch.
    // ------------------------------------------------------------------
    initial begin : color_sink
        sink_mode_t mode;
        int         mode_left;
        logic [7:0] mask;
        color_if.ready <= 1'b0;
        mode = SINK_OPEN;
        mode_left = 0;
        mask = '1;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                color_if.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge i_clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode = sink_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 64);
                mask = 8'($urandom);
            end
            mode_left--;
            case (mode)
                SINK_OPEN: begin
                    color_if.ready <= 1'b1;
                end
                SINK_RANDOM: begin
                    color_if.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    color_if.ready <= mask[0];
                    mask = {mask[0], mask[7:1]};
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Check every accepted color against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_colors
        key_color_t want;
        if (i_rst_n && color_if.valid && color_if.ready) begin
            if (color_queue.size() == 0) begin
                note_mismatch($sformatf("color for key %0d with nothing pending",
                                        color_if.out_key));
            end else begin
                want = color_queue.pop_front();
                if (color_if.out_key !== want.key)
                    note_mismatch($sformatf("key %0d, want %0d", color_if.out_key, want.key));
                if (color_if.red !== want.red)
                    note_mismatch($sformatf("key %0d red %0d, want %0d",
                                            want.key, color_if.red, want.red));
                if (color_if.green !== want.green)
                    note_mismatch($sformatf("key %0d green %0d, want %0d",
                                            want.key, color_if.green, want.green));
                if (color_if.blue !== want.blue)
                    note_mismatch($sformatf("key %0d blue %0d, want %0d",
                                            want.key, color_if.blue, want.blue));
                colors_checked++;
            end
        end
    end

    // Count cycles and input stalls; end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (key_if.valid && !key_if.ready)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d colors pending",
                     cycle_count, color_queue.size());
            $display("[flame_heat_led_effect] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int k;
        error_count = 0;
        keys_sent = 0;
        colors_checked = 0;
        configs_applied = 0;
        cycle_count = 0;
        input_stall_cycles = 0;
        hold_count = 0;
        burst_left = 0;
        gap_max = 4;
        valid_high = 1'b0;
        hold_request = 1'b0;

        // model state after reset
        for (k = 0; k < NUM_KEYS; k++)
            key_heat[k] = HEAT_RESET;
        phase_count    = '0;
        update_active  = 1'b0;
        speed_setting  = SPEED_RESET;
        smooth_setting = SMOOTH_RESET;

        // drive every input known while reset is held
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_FLAME_SPEED;
        i_cfg_data         <= '0;
        key_if.valid       <= 1'b0;
        key_if.key_index   <= '0;
        key_if.key_row     <= '0;
        key_if.random_word <= '0;
        key_if.frame_start <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_first_frame();
        test_config_extremes();
        test_interval_shrink();
        test_backpressure();
        test_random_frames(80, SPEED_FAST, 4'd0, 6);
        test_random_frames(80, 4'd0, 4'd10, 4);
        test_random_frames(80, 4'd15, 4'd15, 0);
        test_random_frames(80, SPEED_RESET, SMOOTH_RESET, 8);
        test_random_frames(80, CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)), 6);
        test_random_frames(60, 4'd11, 4'd12, 3);

        // let any late item show up before judging
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d key items, checked %0d colors across %0d speed/smoothing settings.",
                 keys_sent, colors_checked, configs_applied);
        $display("Color side held off %0d cycles once; key input stalled %0d cycles in all.",
                 HOLD_CYCLES, input_stall_cycles);
        if (error_count == 0 && color_queue.size() == 0) begin
            $display("[flame_heat_led_effect] OK");
        end else begin
            $display("%0d mismatches, %0d colors never returned",
                     error_count, color_queue.size());
            $display("[flame_heat_led_effect] ERROR");
        end
        $finish;
    end

endmodule
